@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/cle_pkg.sv @@
// ----------------------------------------------------------------------------
// cle_pkg
// Types and constants shared by the command line editor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cle_pkg;

  // Line storage: a full line holds LINE_LEN-1 bytes
  localparam int LINE_LEN = 32;
  localparam int LEN_W    = $clog2(LINE_LEN);

  localparam logic [7:0] SPACE_CHAR = 8'h20;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LF    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ERASE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ABORT = 2'd3;

  localparam logic [7:0] RST_CR    = 8'h0D;
  localparam logic [7:0] RST_LF    = 8'h0A;
  localparam logic [7:0] RST_ERASE = 8'h08;
  localparam logic [7:0] RST_ABORT = 8'h03;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD,
    ST_CR,
    ST_LF,
    ST_ER1,
    ST_SP,
    ST_ER2,
    ST_ECHO
  } state_e;

  typedef enum logic [2:0] {
    SEL_RX,
    SEL_STORE,
    SEL_CR,
    SEL_LF,
    SEL_ERASE,
    SEL_SPACE
  } out_sel_e;

  typedef struct packed {
    logic     load_rx;
    logic     store_wr;
    logic     len_inc;
    logic     len_dec;
    logic     len_clr;
    logic     idx_clr;
    logic     idx_inc;
    logic     out_load;
    out_sel_e out_sel;
    logic     to_cmd;
    logic     last;
  } cle_cmd_t;

  typedef struct packed {
    logic is_crlf;
    logic is_erase;
    logic is_abort;
    logic is_nul;
    logic empty;
    logic full;
    logic idx_end;
    logic out_free;
  } cle_sts_t;

endpackage

`default_nettype wire

@@ src/cle_ctrl.sv @@
// ----------------------------------------------------------------------------
// cle_ctrl
// Controller: classifies an accepted byte and sequences its result transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_ctrl
  import cle_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     rx_valid_i,
  output logic          rx_ready_o,
  input  wire cle_sts_t sts_i,
  output cle_cmd_t      cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.out_sel = SEL_RX;
    rx_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        rx_ready_o = 1'b1;
        if (rx_valid_i) begin
          cmd_o.load_rx = 1'b1;
          if (sts_i.is_crlf) begin
            if (sts_i.empty) begin
              state_d = ST_CR;
            end else begin
              cmd_o.idx_clr = 1'b1;
              state_d       = ST_CMD;
            end
          end else if (sts_i.is_erase) begin
            if (!sts_i.empty) begin
              cmd_o.len_dec = 1'b1;
              state_d       = ST_ER1;
            end
          end else if (sts_i.is_abort) begin
            cmd_o.len_clr = 1'b1;
            state_d       = ST_CR;
          end else if (!sts_i.full) begin
            // store unless NUL, echo either way
            cmd_o.store_wr = !sts_i.is_nul;
            cmd_o.len_inc  = !sts_i.is_nul;
            state_d        = ST_ECHO;
          end
        end
      end
      ST_CMD: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SEL_STORE;
          cmd_o.to_cmd   = 1'b1;
          cmd_o.idx_inc  = 1'b1;
          if (sts_i.idx_end) begin
            state_d = ST_CR;
          end
        end
      end
      ST_CR: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SEL_CR;
          state_d        = ST_LF;
        end
      end
      ST_LF: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SEL_LF;
          cmd_o.last     = 1'b1;
          cmd_o.len_clr  = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_ER1: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SEL_ERASE;
          state_d        = ST_SP;
        end
      end
      ST_SP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SEL_SPACE;
          state_d        = ST_ER2;
        end
      end
      ST_ER2: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SEL_ERASE;
          cmd_o.last     = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_ECHO: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SEL_RX;
          cmd_o.last     = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/cle_dp.sv @@
// ----------------------------------------------------------------------------
// cle_dp
// Datapath: control character registers, line store, length and walk index,
// byte classification and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_dp
  import cle_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [7:0]           cfg_data_i,
  input  wire logic [7:0]           rx_byte_i,
  input  wire logic                 out_ready_i,
  input  wire cle_cmd_t             cmd_i,
  output cle_sts_t                  sts_o,
  output logic                      out_valid_o,
  output logic [7:0]                out_byte_o,
  output logic                      to_command_o,
  output logic                      cmd_start_o,
  output logic                      last_o
);

  logic [7:0]       cr_q, lf_q, erase_q, abort_q;
  logic [7:0]       rx_q;
  logic [7:0]       line_mem [LINE_LEN];
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] idx_q, idx_d;
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             to_cmd_q, start_q, last_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_q    <= RST_CR;
      lf_q    <= RST_LF;
      erase_q <= RST_ERASE;
      abort_q <= RST_ABORT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CR:    cr_q    <= cfg_data_i;
        REG_LF:    lf_q    <= cfg_data_i;
        REG_ERASE: erase_q <= cfg_data_i;
        REG_ABORT: abort_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Latch the accepted byte and write it into the line
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_rx) begin
      rx_q <= rx_byte_i;
    end
    if (cmd_i.store_wr) begin
      line_mem[len_q] <= rx_byte_i;
    end
  end

  // Line length and walk index
  always_comb begin
    len_d = len_q;
    if (cmd_i.len_clr) begin
      len_d = '0;
    end else if (cmd_i.len_inc) begin
      len_d = len_q + LEN_W'(1);
    end else if (cmd_i.len_dec) begin
      len_d = len_q - LEN_W'(1);
    end
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      idx_q <= '0;
    end else begin
      len_q <= len_d;
      idx_q <= idx_d;
    end
  end

  // Classify the incoming byte and report line status
  always_comb begin
    sts_o.is_crlf  = (rx_byte_i == cr_q) || (rx_byte_i == lf_q);
    sts_o.is_erase = (rx_byte_i == erase_q);
    sts_o.is_abort = (rx_byte_i == abort_q);
    sts_o.is_nul   = (rx_byte_i == 8'h00);
    sts_o.empty    = (len_q == '0);
    sts_o.full     = (len_q == LEN_W'(LINE_LEN - 1));
    sts_o.idx_end  = (idx_q == len_q - LEN_W'(1));
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  // Output register: load a result, drop it once transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Select the result byte and hold it with its flags
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (cmd_i.out_sel)
        SEL_RX:    out_byte_q <= rx_q;
        SEL_STORE: out_byte_q <= line_mem[idx_q];
        SEL_CR:    out_byte_q <= cr_q;
        SEL_LF:    out_byte_q <= lf_q;
        SEL_ERASE: out_byte_q <= erase_q;
        SEL_SPACE: out_byte_q <= SPACE_CHAR;
        default:   out_byte_q <= rx_q;
      endcase
      to_cmd_q   <= cmd_i.to_cmd;
      start_q    <= cmd_i.to_cmd && (idx_q == '0);
      last_q     <= cmd_i.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign to_command_o = to_cmd_q;
  assign cmd_start_o  = start_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

@@ src/command_line_editor.sv @@
// An accepted byte is registered, then its results are loaded into the output
// register one per cycle while out_ready_i stays high (line end: stored
// length + 2 results, erase: 3); the next byte waits for the last to load.
// At a line end the walk reads one stored byte per cycle while not stalled.
// Reset: asynchronous, active low; clears the line and restores the default
// control characters (CR 0x0D, LF 0x0A, BS 0x08, abort 0x03).
// ----------------------------------------------------------------------------
// command_line_editor
// Terminal line editor: echo, erase, abort and command run on line end.
// ----------------------------------------------------------------------------
`default_nettype none

module command_line_editor
  import cle_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [7:0]           cfg_data_i,
  input  wire logic                 rx_valid_i,
  output logic                      rx_ready_o,
  input  wire logic [7:0]           rx_byte_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [7:0]                out_byte_o,
  output logic                      to_command_o,
  output logic                      cmd_start_o,
  output logic                      last_o
);

  cle_cmd_t cmd;
  cle_sts_t sts;

  // Sequence control
  cle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Line storage and result register
  cle_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .rx_byte_i    (rx_byte_i),
    .out_ready_i  (out_ready_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .to_command_o (to_command_o),
    .cmd_start_o  (cmd_start_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

@@ src/cle_checker.sv @@
// ----------------------------------------------------------------------------
// cle_checker
// Port-level checks on the editor's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cle_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       to_command_o,
  input wire logic       cmd_start_o,
  input wire logic       last_o
);

  // Hold a stalled result
  `ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")
  `ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_byte_o), "stalled byte moved")

  // A command run start is always a command byte
  `ASSERT_IMPL(a_start_cmd, out_valid_o && cmd_start_o, to_command_o, "start flag on echo byte")

  // A command byte is never the final result: CR LF always follow
  `ASSERT_IMPL(a_cmd_not_last, out_valid_o && to_command_o, !last_o, "command byte marked last")

endmodule

bind command_line_editor cle_checker u_cle_checker (.*);

`default_nettype wire

@@ tb/cle_echo_checker.sv @@
// ----------------------------------------------------------------------------
// cle_echo_checker
// Watches the byte, result and register ports of the line editor. Keeps its
// own copy of the control characters and the stored line, works out the
// echo and command bytes that each accepted byte must cause, and compares
// every result transfer with the oldest of them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cle_echo_checker
  import cle_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 rx_valid_i,
  input  logic                 rx_ready_i,
  input  logic [7:0]           rx_byte_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [7:0]           out_byte_i,
  input  logic                 to_command_i,
  input  logic                 cmd_start_i,
  input  logic                 last_i,
  output int                   error_count_o,
  output int                   pending_count_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       to_cmd;
    logic       start;
    logic       is_last;
  } echo_t;

  // Shadow copy of the control characters
  logic [7:0] cr_q;
  logic [7:0] lf_q;
  logic [7:0] erase_q;
  logic [7:0] abort_q;

  // Shadow copy of the edited line
  logic [7:0]       line_mem [LINE_LEN];
  logic [LEN_W-1:0] line_len;

  echo_t pending_echo_q [$];
  echo_t want;

  function automatic echo_t make_echo(logic [7:0] data, logic to_cmd, logic start);
    echo_t e;
    e.data    = data;
    e.to_cmd  = to_cmd;
    e.start   = start;
    e.is_last = 1'b0;
    return e;
  endfunction

  // Work out the results of one keystroke and queue them in order
  task automatic predict_keystroke(input logic [7:0] c);
    echo_t            run_q [$];
    echo_t            e;
    logic [LEN_W-1:0] len;
    len = line_len;
    if (c == cr_q || c == lf_q) begin
      for (int i = 0; i < len; i++) begin
        run_q.push_back(make_echo(line_mem[LEN_W'(i)], 1'b1, i == 0));
      end
      run_q.push_back(make_echo(cr_q, 1'b0, 1'b0));
      run_q.push_back(make_echo(lf_q, 1'b0, 1'b0));
      line_len = '0;
    end else if (c == erase_q) begin
      if (len > 0) begin
        run_q.push_back(make_echo(erase_q, 1'b0, 1'b0));
        run_q.push_back(make_echo(SPACE_CHAR, 1'b0, 1'b0));
        run_q.push_back(make_echo(erase_q, 1'b0, 1'b0));
        line_len = len - 1'b1;
      end
    end else if (c == abort_q) begin
      line_len = '0;
      run_q.push_back(make_echo(cr_q, 1'b0, 1'b0));
      run_q.push_back(make_echo(lf_q, 1'b0, 1'b0));
    end else if (len < LINE_LEN - 1) begin
      // NUL is echoed but never stored
      if (c != 8'h00) begin
        line_mem[len] = c;
        line_len = len + 1'b1;
      end
      run_q.push_back(make_echo(c, 1'b0, 1'b0));
    end
    // Flag the final result of this keystroke
    for (int k = 0; k < run_q.size(); k++) begin
      e = run_q[k];
      e.is_last = (k == run_q.size() - 1);
      pending_echo_q.push_back(e);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_q     = RST_CR;
      lf_q     = RST_LF;
      erase_q  = RST_ERASE;
      abort_q  = RST_ABORT;
      line_len = '0;
      pending_echo_q.delete();
      error_count_o   = 0;
      pending_count_o = 0;
    end else begin
      // Compare a result transfer with the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (pending_echo_q.size() == 0) begin
          $error("result with nothing expected: out_byte %0h", out_byte_i);
          error_count_o++;
        end else begin
          want = pending_echo_q.pop_front();
          if (out_byte_i !== want.data) begin
            $error("out_byte: expected %0h, actual %0h", want.data, out_byte_i);
            error_count_o++;
          end
          if (to_command_i !== want.to_cmd) begin
            $error("to_command: expected %0b, actual %0b", want.to_cmd, to_command_i);
            error_count_o++;
          end
          if (cmd_start_i !== want.start) begin
            $error("cmd_start: expected %0b, actual %0b", want.start, cmd_start_i);
            error_count_o++;
          end
          if (last_i !== want.is_last) begin
            $error("last: expected %0b, actual %0b", want.is_last, last_i);
            error_count_o++;
          end
        end
      end
      // Predict a byte transfer
      if (rx_valid_i && rx_ready_i) begin
        predict_keystroke(rx_byte_i);
      end
      // Track register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CR:    cr_q    = cfg_data_i;
          REG_LF:    lf_q    = cfg_data_i;
          REG_ERASE: erase_q = cfg_data_i;
          REG_ABORT: abort_q = cfg_data_i;
          default: ;
        endcase
      end
      pending_count_o = pending_echo_q.size();
    end
  end

endmodule

@@ tb/command_line_editor_test.sv @@
// ----------------------------------------------------------------------------
// command_line_editor_test
// Drives keystrokes and register writes into the line editor with random
// gaps and output stalls: a directed opening over the special cases, then
// random lines under several control character settings. A separate checker
// predicts and compares the results; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module command_line_editor_test;
  import cle_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASE_ITEMS = 75;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [7:0]           cfg_data_i;
  logic                 rx_valid_i;
  logic                 rx_ready_o;
  logic [7:0]           rx_byte_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [7:0]           out_byte_o;
  logic                 to_command_o;
  logic                 cmd_start_o;
  logic                 last_o;

  int error_count;
  int pending_count;
  int idle_cycles;

  // Stimulus copy of the control characters, used to build whole lines
  logic [7:0] cr_sel;
  logic [7:0] lf_sel;
  logic [7:0] erase_sel;
  logic [7:0] abort_sel;

  logic rx_idle_en;
  logic out_idle_en;

  command_line_editor dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .rx_valid_i   (rx_valid_i),
    .rx_ready_o   (rx_ready_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .to_command_o (to_command_o),
    .cmd_start_o  (cmd_start_o),
    .last_o       (last_o)
  );

  cle_echo_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .rx_valid_i      (rx_valid_i),
    .rx_ready_i      (rx_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_i      (out_byte_o),
    .to_command_i    (to_command_o),
    .cmd_start_i     (cmd_start_o),
    .last_i          (last_o),
    .error_count_o   (error_count),
    .pending_count_o (pending_count)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Abort the run when nothing has been transferred for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (rx_valid_i && rx_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("command_line_editor verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: with out_idle_en set, stall at random before each transfer
  initial begin : result_sink
    int stall;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = out_idle_en ? $urandom_range(0, 13) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Present one keystroke after a random gap and hold it until the transfer
  task automatic send_key(input logic [7:0] key);
    int gap;
    gap = rx_idle_en ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      rx_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= key;
    @(posedge clk_i);
    while (!rx_ready_o) @(posedge clk_i);
  endtask

  // Hold off the sender until every expected result has come out
  task automatic drain_results();
    rx_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    // Dropped keystrokes give no result; let the block settle
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_ctrl(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_controls(input logic [7:0] cr, input logic [7:0] lf,
                              input logic [7:0] erase, input logic [7:0] abort);
    drain_results();
    write_ctrl(REG_CR, cr);
    write_ctrl(REG_LF, lf);
    write_ctrl(REG_ERASE, erase);
    write_ctrl(REG_ABORT, abort);
    cr_sel    = cr;
    lf_sel    = lf;
    erase_sel = erase;
    abort_sel = abort;
  endtask

  // Mostly whole lines with random content, some edits, some noise
  task automatic type_lines(input int count);
    int sent;
    int line_bytes;
    int pick;
    sent = 0;
    while (sent < count) begin
      rx_idle_en  = ($urandom_range(0, 3) != 0);
      out_idle_en = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) begin
        send_key(8'($urandom_range(0, 255)));
        sent++;
      end else begin
        line_bytes = ($urandom_range(0, 6) == 0) ? $urandom_range(26, 40)
                                                 : $urandom_range(0, 10);
        for (int k = 0; k < line_bytes; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 8) send_key(erase_sel);
          else if (pick < 10) send_key(abort_sel);
          else if (pick < 13) send_key(8'h00);
          else send_key(8'($urandom_range(0, 255)));
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) send_key(abort_sel);
        else if (pick < 5) send_key(cr_sel);
        else send_key(lf_sel);
        sent += line_bytes + 1;
        if ($urandom_range(0, 9) == 0) drain_results();
      end
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_CR;
    cfg_data_i  <= 8'h00;
    rx_valid_i  <= 1'b0;
    rx_byte_i   <= 8'h00;
    rx_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    cr_sel      = RST_CR;
    lf_sel      = RST_LF;
    erase_sel   = RST_ERASE;
    abort_sel   = RST_ABORT;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: byte extremes, NUL, erase, line ends and abort, empty and not
    send_key(8'h61);
    send_key(8'h00);
    send_key(8'hFF);
    send_key(8'h80);
    send_key(8'h7F);
    send_key(RST_ERASE);
    send_key(RST_ERASE);
    send_key(RST_CR);
    send_key(RST_ERASE);
    send_key(RST_LF);
    send_key(RST_ABORT);
    send_key(8'h78);
    send_key(8'h79);
    send_key(RST_ABORT);
    send_key(8'h71);
    send_key(8'h01);
    send_key(RST_LF);
    send_key(RST_CR);
    send_key(8'h55);
    send_key(8'hAA);
    send_key(RST_ERASE);
    send_key(RST_CR);

    // Extremes, including a register value of 255
    set_controls(8'h00, 8'hFF, 8'h7F, 8'hFE);
    type_lines(PHASE_ITEMS);
    // All equal: line end wins on priority
    set_controls(8'h41, 8'h41, 8'h41, 8'h41);
    type_lines(PHASE_ITEMS);
    // Erase equal to abort, line feed at the top
    set_controls(8'h0D, 8'hFF, 8'h00, 8'h00);
    type_lines(PHASE_ITEMS);
    set_controls(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    type_lines(PHASE_ITEMS);
    set_controls(RST_CR, RST_LF, RST_ERASE, RST_ABORT);
    type_lines(PHASE_ITEMS);

    drain_results();
    repeat (30) @(posedge clk_i);
    if (error_count == 0) begin
      $display("command_line_editor verification clean");
    end else begin
      $display("command_line_editor verification failed");
    end
    $finish;
  end

endmodule
